// ===== design/clle_pkg.sv =====
// Shared types and codes for the cursor linked list engine.
`default_nettype none

package clle_pkg;

    localparam int ID_W   = 16;
    localparam int PL_W   = 32;
    localparam int CRES_W = 6;
    localparam int DATA_W = ID_W + PL_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [7:0] position;
        logic [ID_W-1:0]   article_id;
        logic [PL_W-1:0]   payload;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CRES_W-1:0] cell_res;
        logic [ID_W-1:0]   found_id;
        logic [PL_W-1:0]   found_payload;
    } result_t;

endpackage

`default_nettype wire

// ===== design/cursor_linked_list_engine_unit.sv =====
// Top level: linked list engine with link and data memories and the operation sequencer.
//
// Usage: drive item and pulse start while busy is low; the item is taken at that edge.
// Exactly one result per item appears on result for one cycle with done high; the
// receiver cannot stall it. Results come back in item order.
// Paths from start to done, one link memory read per walked cell:
//   immediate errors (store full, position below -1, empty list, unused opcode): answered from idle
//   insert at head or into an empty list: free cell read, then one link write
//   insert after k-th element: free cell read, walk of k cells, then two link writes
//   insert at tail: free cell read, walk of the whole list, then two link writes
//   search: walk up to the match (or list end); delete: one or two more writes for unlinking
// The walk loop through the synchronous link memory sets the rate: one cell per cycle.
// busy is high while an item is in work; the next item may be given in the cycle that
// done is shown.
// Reset: the free list chain is rebuilt by a sweep over every cell of the link memory;
// busy stays high during it. The list starts empty.
`default_nettype none

module cursor_linked_list_engine_unit #(
    parameter int CELL_COUNT = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire clle_pkg::item_t  item,
    output logic                  done,
    output clle_pkg::result_t     result
);
    import clle_pkg::*;

    localparam int IW = $clog2(CELL_COUNT);
    localparam int LW = $clog2(CELL_COUNT + 1);
    localparam logic [LW-1:0] LINK_NULL = LW'(CELL_COUNT);
    localparam logic [IW-1:0] LAST_CELL = IW'(CELL_COUNT - 1);

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_FREE_RD = 9'b000000100,
        S_IWALK   = 9'b000001000,
        S_LINK_A  = 9'b000010000,
        S_LINK_B  = 9'b000100000,
        S_SWALK   = 9'b001000000,
        S_DUNLINK = 9'b010000000,
        S_DFREE   = 9'b100000000
    } state_t;

    logic [LW-1:0]     link_mem [CELL_COUNT];
    logic [DATA_W-1:0] data_mem [CELL_COUNT];

    state_t            state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [LW-1:0]     free_head_reg, free_head_next;
    logic [LW-1:0]     list_head_reg, list_head_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;
    logic [1:0]        op_reg, op_next;
    logic [7:0]        pos_reg, pos_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PL_W-1:0]   pl_reg, pl_next;
    logic [LW-1:0]     free_next_reg, free_next_next;
    logic [LW-1:0]     cur_reg, cur_next;
    logic [LW-1:0]     prev_reg, prev_next;
    logic [LW-1:0]     succ_reg, succ_next;
    logic [6:0]        rem_reg, rem_next;

    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              lk_we;
    logic [IW-1:0]     lk_waddr;
    logic [LW-1:0]     lk_wdata;
    logic              dt_we;
    logic [LW-1:0]     lk_rdata_reg;
    logic [DATA_W-1:0] dt_rdata_reg;
    logic [ID_W-1:0]   rd_id;
    logic [PL_W-1:0]   rd_pl;

    function automatic logic is_cell(input logic [LW-1:0] c);
        return c < LINK_NULL;
    endfunction

    function automatic result_t make_res(input logic [2:0] st, input logic [LW-1:0] cell_num,
                                         input logic [ID_W-1:0] id,
                                         input logic [PL_W-1:0] pl);
        result_t r;
        r.status        = st;
        r.cell_res      = (st == ST_OK) ? CRES_W'(cell_num) : '0;
        r.found_id      = id;
        r.found_payload = pl;
        return r;
    endfunction

    assign rd_id = dt_rdata_reg[DATA_W-1:PL_W];
    assign rd_pl = dt_rdata_reg[PL_W-1:0];

    // memories
    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        if (dt_we)
        begin
            data_mem[free_head_reg[IW-1:0]] <= {id_reg, pl_reg};
        end
        if (rd_en)
        begin
            lk_rdata_reg <= link_mem[rd_addr];
            dt_rdata_reg <= data_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        id_next        = id_reg;
        pl_next        = pl_reg;
        free_next_next = free_next_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        succ_next      = succ_reg;
        rem_next       = rem_reg;
        rd_en          = 1'b0;
        rd_addr        = free_head_reg[IW-1:0];
        lk_we          = 1'b0;
        lk_waddr       = free_head_reg[IW-1:0];
        lk_wdata       = succ_reg;
        dt_we          = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                lk_we    = 1'b1;
                lk_waddr = clr_reg;
                lk_wdata = LW'(clr_reg) + LW'(1);
                clr_next = clr_reg + IW'(1);
                if (clr_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = item.opcode;
                    pos_next = item.position;
                    id_next  = item.article_id;
                    pl_next  = item.payload;
                    case (item.opcode)
                        OP_INSERT:
                        begin
                            if (!is_cell(free_head_reg))
                            begin
                                done_next = 1'b1;
                                res_next  = make_res(ST_FULL, '0, '0, '0);
                            end
                            else if ($signed(item.position) < -8'sd1)
                            begin
                                done_next = 1'b1;
                                res_next  = make_res(ST_BADPOS, '0, '0, '0);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = free_head_reg[IW-1:0];
                                state_next = S_FREE_RD;
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (!is_cell(list_head_reg))
                            begin
                                done_next = 1'b1;
                                res_next  = make_res((item.opcode == OP_DELETE) ? ST_EMPTY
                                                     : ST_NOTFOUND, '0, '0, '0);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = list_head_reg[IW-1:0];
                                cur_next   = list_head_reg;
                                prev_next  = LINK_NULL;
                                state_next = S_SWALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = make_res(ST_BADPOS, '0, '0, '0);
                        end
                    endcase
                end
            end
            S_FREE_RD:
            begin
                free_next_next = lk_rdata_reg;
                dt_we          = 1'b1;
                if (pos_reg == 8'h00)
                begin
                    succ_next  = list_head_reg;
                    prev_next  = LINK_NULL;
                    state_next = S_LINK_A;
                end
                else if (!is_cell(list_head_reg))
                begin
                    if (pos_reg == 8'hFF)
                    begin
                        succ_next  = LINK_NULL;
                        prev_next  = LINK_NULL;
                        state_next = S_LINK_A;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        res_next   = make_res(ST_BADPOS, '0, '0, '0);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = list_head_reg[IW-1:0];
                    cur_next   = list_head_reg;
                    rem_next   = pos_reg[6:0] - 7'd1;
                    state_next = S_IWALK;
                end
            end
            S_IWALK:
            begin
                if (pos_reg == 8'hFF)
                begin
                    if (is_cell(lk_rdata_reg))
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = lk_rdata_reg[IW-1:0];
                        cur_next = lk_rdata_reg;
                    end
                    else
                    begin
                        prev_next  = cur_reg;
                        succ_next  = LINK_NULL;
                        state_next = S_LINK_A;
                    end
                end
                else if (rem_reg == 7'd0)
                begin
                    prev_next  = cur_reg;
                    succ_next  = lk_rdata_reg;
                    state_next = S_LINK_A;
                end
                else
                begin
                    rem_next = rem_reg - 7'd1;
                    if (is_cell(lk_rdata_reg))
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = lk_rdata_reg[IW-1:0];
                        cur_next = lk_rdata_reg;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        res_next   = make_res(ST_BADPOS, '0, '0, '0);
                        state_next = S_IDLE;
                    end
                end
            end
            S_LINK_A:
            begin
                lk_we    = 1'b1;
                lk_waddr = free_head_reg[IW-1:0];
                lk_wdata = succ_reg;
                if (!is_cell(prev_reg))
                begin
                    list_head_next = free_head_reg;
                    free_head_next = free_next_reg;
                    done_next      = 1'b1;
                    res_next       = make_res(ST_OK, free_head_reg, '0, '0);
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_LINK_B;
                end
            end
            S_LINK_B:
            begin
                lk_we          = 1'b1;
                lk_waddr       = prev_reg[IW-1:0];
                lk_wdata       = free_head_reg;
                free_head_next = free_next_reg;
                done_next      = 1'b1;
                res_next       = make_res(ST_OK, free_head_reg, '0, '0);
                state_next     = S_IDLE;
            end
            S_SWALK:
            begin
                if (rd_id == id_reg)
                begin
                    if (op_reg == OP_SEARCH)
                    begin
                        done_next  = 1'b1;
                        res_next   = make_res(ST_OK, cur_reg, rd_id, rd_pl);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        succ_next = lk_rdata_reg;
                        if (!is_cell(prev_reg))
                        begin
                            list_head_next = lk_rdata_reg;
                            state_next     = S_DFREE;
                        end
                        else
                        begin
                            state_next = S_DUNLINK;
                        end
                    end
                end
                else if (!is_cell(lk_rdata_reg))
                begin
                    done_next  = 1'b1;
                    res_next   = make_res(ST_NOTFOUND, '0, '0, '0);
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = lk_rdata_reg[IW-1:0];
                    prev_next = cur_reg;
                    cur_next  = lk_rdata_reg;
                end
            end
            S_DUNLINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = prev_reg[IW-1:0];
                lk_wdata   = succ_reg;
                state_next = S_DFREE;
            end
            S_DFREE:
            begin
                lk_we          = 1'b1;
                lk_waddr       = cur_reg[IW-1:0];
                lk_wdata       = free_head_reg;
                free_head_next = cur_reg;
                done_next      = 1'b1;
                res_next       = make_res(ST_OK, cur_reg, '0, '0);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            free_head_reg <= '0;
            list_head_reg <= LINK_NULL;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        id_reg        <= id_next;
        pl_reg        <= pl_next;
        free_next_reg <= free_next_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        succ_reg      <= succ_next;
        rem_reg       <= rem_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== design/clle_checker.sv =====
// Port-level checks for the linked list engine, bound to the top level.
`default_nettype none

module clle_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire clle_pkg::item_t   item,
    input wire logic              done,
    input wire clle_pkg::result_t result
);
    import clle_pkg::*;

    logic [1:0] item_op;
    assign item_op = item.opcode;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither in work nor answered");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || ($past(start) && !$past(busy)))
        else $error("result without an item");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ST_EMPTY)
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |->
            result.cell_res == '0 && result.found_id == '0 && result.found_payload == '0)
        else $error("error result carries data");

    a_bad_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item_op != OP_INSERT && item_op != OP_DELETE
            && item_op != OP_SEARCH |=> done && result.status == ST_BADPOS)
        else $error("unused opcode not rejected");

endmodule

bind cursor_linked_list_engine_unit clle_checker u_clle_checker (.*);

`default_nettype wire
